// File: rtl/slx_pkg.sv
package slx_pkg;

  localparam logic [2:0] KIND_CHAR         = 3'd0;
  localparam logic [2:0] KIND_END_WORD     = 3'd1;
  localparam logic [2:0] KIND_PIPE         = 3'd2;
  localparam logic [2:0] KIND_REDIR_OUT    = 3'd3;
  localparam logic [2:0] KIND_REDIR_APPEND = 3'd4;
  localparam logic [2:0] KIND_REDIR_IN     = 3'd5;
  localparam logic [2:0] KIND_END_LINE     = 3'd6;

  localparam logic [1:0] QM_NONE   = 2'd0;
  localparam logic [1:0] QM_SINGLE = 2'd1;
  localparam logic [1:0] QM_DOUBLE = 2'd2;

  localparam logic [1:0] PEND_NONE      = 2'd0;
  localparam logic [1:0] PEND_BSLASH    = 2'd1;
  localparam logic [1:0] PEND_DQ_BSLASH = 2'd2;
  localparam logic [1:0] PEND_GT        = 2'd3;

  localparam logic [7:0] CH_PIPE   = 8'h7c;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam int unsigned SLX_MAX_TOKENS  = 4;
  localparam int unsigned SLX_QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
  } slx_tok_t;

  typedef struct packed {
    logic [1:0] quote;
    logic       word_open;
    logic [1:0] pend;
  } slx_state_t;

  // All tokens caused by one input byte; tok[0] is delivered first.
  typedef struct packed {
    slx_tok_t [SLX_MAX_TOKENS-1:0] tok;
    logic [2:0]                    cnt;
  } slx_rec_t;

  typedef struct packed {
    slx_state_t st;
    slx_rec_t   rec;
  } slx_work_t;

  function automatic slx_work_t slx_emit(slx_work_t w, logic [2:0] kind, logic [7:0] c);
    slx_work_t r;
    r = w;
    if (w.rec.cnt < 3'd4) begin
      r.rec.tok[w.rec.cnt[1:0]].kind = kind;
      r.rec.tok[w.rec.cnt[1:0]].ch   = (kind == KIND_CHAR) ? c : 8'h00;
      r.rec.cnt = w.rec.cnt + 3'd1;
    end
    return r;
  endfunction

  function automatic slx_work_t slx_put_char(slx_work_t w, logic [7:0] c);
    slx_work_t r;
    r = slx_emit(w, KIND_CHAR, c);
    r.st.word_open = 1'b1;
    return r;
  endfunction

  function automatic slx_work_t slx_end_word(slx_work_t w);
    slx_work_t r;
    r = w;
    if (w.st.word_open) begin
      r = slx_emit(w, KIND_END_WORD, 8'h00);
      r.st.word_open = 1'b0;
    end
    return r;
  endfunction

  function automatic logic slx_is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[8'd9:8'd13]});
  endfunction

  function automatic slx_work_t slx_handle(slx_work_t w, logic [7:0] c);
    slx_work_t r;
    r = w;
    if (w.st.quote == QM_SINGLE) begin
      if (c == CH_SQUOTE) r.st.quote = QM_NONE;
      else r = slx_put_char(w, c);
    end else if (w.st.quote == QM_DOUBLE) begin
      if (c == CH_DQUOTE) r.st.quote = QM_NONE;
      else if (c == CH_BSLASH) r.st.pend = PEND_DQ_BSLASH;
      else r = slx_put_char(w, c);
    end else begin
      r.st.quote = QM_NONE;
      if (slx_is_space(c)) begin
        r = slx_end_word(r);
      end else if (c == CH_SQUOTE) begin
        r.st.quote = QM_SINGLE;
      end else if (c == CH_DQUOTE) begin
        r.st.quote = QM_DOUBLE;
      end else if (c == CH_BSLASH) begin
        r.st.pend = PEND_BSLASH;
      end else if (c == CH_PIPE) begin
        r = slx_end_word(r);
        r = slx_emit(r, KIND_PIPE, 8'h00);
      end else if (c == CH_GT) begin
        r = slx_end_word(r);
        r.st.pend = PEND_GT;
      end else if (c == CH_LT) begin
        r = slx_end_word(r);
        r = slx_emit(r, KIND_REDIR_IN, 8'h00);
      end else begin
        r = slx_put_char(r, c);
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/slx_front.sv
module slx_front import slx_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  input  logic     q_full_i,
  input  logic [7:0] ch_i,
  input  logic     line_end_i,
  output logic     rec_wr_o,
  output slx_rec_t rec_o
);

  slx_state_t st_q, st_d;
  slx_work_t  w;
  logic       accept;

  assign accept = push && !q_full_i;

  always_comb begin
    w        = '0;
    w.st     = st_q;
    w.st.pend = PEND_NONE;
    case (st_q.pend)
      PEND_BSLASH: begin
        w = slx_put_char(w, ch_i);
      end
      PEND_DQ_BSLASH: begin
        if (ch_i == CH_DQUOTE || ch_i == CH_BSLASH || ch_i == CH_DOLLAR) begin
          w = slx_put_char(w, ch_i);
        end else begin
          w = slx_put_char(w, CH_BSLASH);
          w = slx_handle(w, ch_i);
        end
      end
      PEND_GT: begin
        if (ch_i == CH_GT) begin
          w = slx_emit(w, KIND_REDIR_APPEND, 8'h00);
        end else begin
          w = slx_emit(w, KIND_REDIR_OUT, 8'h00);
          w = slx_handle(w, ch_i);
        end
      end
      default: begin
        w = slx_handle(w, ch_i);
      end
    endcase
    // The final byte flushes any lookahead, closes the word and returns to reset.
    if (line_end_i) begin
      if (w.st.pend == PEND_BSLASH || w.st.pend == PEND_DQ_BSLASH) begin
        w = slx_put_char(w, CH_BSLASH);
      end else if (w.st.pend == PEND_GT) begin
        w = slx_emit(w, KIND_REDIR_OUT, 8'h00);
      end
      w = slx_end_word(w);
      w = slx_emit(w, KIND_END_LINE, 8'h00);
      w.st = '0;
    end
    st_d = accept ? w.st : st_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  assign rec_wr_o = accept && (w.rec.cnt != 3'd0);
  assign rec_o    = w.rec;

endmodule

// File: rtl/slx_queue.sv
module slx_queue import slx_pkg::*; #(
  parameter int unsigned Depth = SLX_QUEUE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_i,
  input  slx_rec_t wr_data_i,
  input  logic     rd_i,
  output slx_rec_t rd_data_o,
  output logic     full_o,
  output logic     empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  slx_rec_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
    if (do_rd) rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
    if (do_wr && !do_rd) cnt_d = cnt_q + 1'b1;
    else if (do_rd && !do_wr) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

// File: rtl/slx_back.sv
module slx_back import slx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rec_valid_i,
  input  slx_rec_t   rec_i,
  output logic       rec_rd_o,
  input  logic       pop,
  output logic       empty,
  output logic [2:0] kind_o,
  output logic [7:0] word_char_o,
  output logic       run_last_o
);

  logic [1:0] idx_q, idx_d;
  logic       out_vld_q, out_vld_d;
  slx_tok_t   out_tok_q;
  logic       out_last_q;
  logic       load, last_tok;

  // The output register is refilled in the cycle it is taken, so one request
  // per cycle flows out while the record queue is not empty.
  assign load     = rec_valid_i && (!out_vld_q || pop);
  assign last_tok = ({1'b0, idx_q} + 3'd1) == rec_i.cnt;
  assign rec_rd_o = load && last_tok;

  always_comb begin
    idx_d     = idx_q;
    out_vld_d = out_vld_q;
    if (load) begin
      out_vld_d = 1'b1;
      idx_d     = last_tok ? 2'd0 : idx_q + 2'd1;
    end else if (pop) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_tok_q  <= rec_i.tok[idx_q];
      out_last_q <= last_tok;
    end
  end

  assign empty       = !out_vld_q;
  assign kind_o      = out_tok_q.kind;
  assign word_char_o = out_tok_q.ch;
  assign run_last_o  = out_last_q;

endmodule

// File: rtl/shell_command_lexer.sv
// The first result of a byte is written into the record queue and then loaded into the output
// register. Throughput: one byte per cycle in while the queue is not full, one result per cycle
// out while they are popped; the record queue between front and back soaks up bursts.
// Reset (asynchronous, active low) returns the lexer to outside quotes with no open word,
// nothing pending, and empties the record queue and the output register.
module shell_command_lexer import slx_pkg::*; #(
  parameter int unsigned QueueDepth = SLX_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] ch_i,
  input  logic       line_end_i,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] kind_o,
  output logic [7:0] word_char_o,
  output logic       run_last_o
);

  logic     rec_wr, rec_rd, q_empty;
  slx_rec_t rec_in, rec_out;

  slx_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .q_full_i   (full),
    .ch_i       (ch_i),
    .line_end_i (line_end_i),
    .rec_wr_o   (rec_wr),
    .rec_o      (rec_in)
  );

  slx_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (rec_wr),
    .wr_data_i (rec_in),
    .rd_i      (rec_rd),
    .rd_data_o (rec_out),
    .full_o    (full),
    .empty_o   (q_empty)
  );

  slx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (!q_empty),
    .rec_i       (rec_out),
    .rec_rd_o    (rec_rd),
    .pop         (pop),
    .empty       (empty),
    .kind_o      (kind_o),
    .word_char_o (word_char_o),
    .run_last_o  (run_last_o)
  );

endmodule
